// ----- hw/rtl/mm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_pkg
// Shared widths, types and sequencer codes for the modular exponentiation
// core.
// ----------------------------------------------------------------------------
package mm_pkg;

  // datapath width and width of the transaction fields
  localparam int unsigned WIDTH  = 32;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CntW   = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [DataW-1:0] field_t;
  typedef logic [CntW-1:0]  cnt_t;

  typedef enum logic [2:0] {
    StIdle,
    StReduce,
    StCheck,
    StMulAcc,
    StMulSq,
    StFinish
  } mm_state_e;

  // sequencer -> datapath
  typedef struct packed {
    logic in_ready;
    logic accept;
    logic mul_step;
    logic sel_reduce;
    logic start_acc;
    logic start_sq;
    logic end_reduce;
    logic end_acc;
    logic end_sq;
    logic out_load;
  } mm_ctrl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic in_valid;
    logic mod_zero;
    logic exp_zero;
    logic exp_lsb;
    logic cnt_last;
    logic out_busy;
  } mm_status_t;

endpackage

// ----- hw/rtl/mm_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_in_if
// Operand channel: base, exponent and modulus with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mm_in_if;
  logic             valid;
  logic             ready;
  mm_pkg::field_t   base_value;
  mm_pkg::field_t   exponent;
  mm_pkg::field_t   modulus;

  modport source (output valid, output base_value, output exponent,
                  output modulus, input ready);
  modport sink   (input valid, input base_value, input exponent,
                  input modulus, output ready);
endinterface

// ----- hw/rtl/mm_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_out_if
// Result channel: reduced power and modulus error flag with valid/ready.
// ----------------------------------------------------------------------------
interface mm_out_if;
  logic             valid;
  logic             ready;
  mm_pkg::field_t   power_result;
  logic             modulus_error;

  modport source (output valid, output power_result, output modulus_error,
                  input ready);
  modport sink   (input valid, input power_result, input modulus_error,
                  output ready);
endinterface

// ----- hw/rtl/modular_exponentiation_core.sv -----
// Sequence: after acceptance the base is reduced, then each exponent bit up to the top
//   set bit takes a squaring, preceded by an accumulator multiply when the bit is set;
//   a zero modulus goes straight to the result load.
// Throughput: one transaction at a time, the next taken the cycle after the result
//   is loaded; each exponent bit is one or two products on the shared step unit.
// Reset: rst_ni clears the sequencer and the output valid flag.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// Right-to-left square-and-multiply modular exponentiation with a single
// shared shift-add reduction unit.
// ----------------------------------------------------------------------------
module modular_exponentiation_core (
  input  logic clk_i,
  input  logic rst_ni,
  mm_in_if.sink    in_i,
  mm_out_if.source out_o
);
  import mm_pkg::*;

  mm_ctrl_t   ctrl;
  mm_status_t status;

  word_t mod_q, mod_d;
  word_t exp_q, exp_d;
  word_t sq_q, sq_d;
  word_t acc_q, acc_d;
  word_t r_q, r_d;
  word_t mplr_q, mplr_d;
  cnt_t  cnt_q, cnt_d;
  logic  err_q, err_d;
  word_t addend;
  word_t r_next;
  word_t mod_in;
  logic  out_valid_q, out_valid_d;
  field_t res_q, res_d;
  logic  res_err_q, res_err_d;

  assign mod_in = WIDTH'(in_i.modulus);

  // sequencer
  mm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  assign status.in_valid = in_i.valid;
  assign status.mod_zero = (mod_in == '0);
  assign status.exp_zero = (exp_q == '0);
  assign status.exp_lsb  = exp_q[0];
  assign status.cnt_last = (cnt_q == '0);
  assign status.out_busy = out_valid_q && !out_o.ready;

  // shared reduction step; base reduction multiplies by one
  assign addend = mplr_q[WIDTH-1] ? (ctrl.sel_reduce ? word_t'(1) : sq_q) : '0;

  mm_step_unit u_step (
    .r_i      (r_q),
    .addend_i (addend),
    .mod_i    (mod_q),
    .r_o      (r_next)
  );

  // operand and working registers
  always_comb begin
    mod_d  = mod_q;
    exp_d  = exp_q;
    sq_d   = sq_q;
    acc_d  = acc_q;
    r_d    = r_q;
    mplr_d = mplr_q;
    cnt_d  = cnt_q;
    err_d  = err_q;
    if (ctrl.mul_step) begin
      r_d    = r_next;
      mplr_d = {mplr_q[WIDTH-2:0], 1'b0};
      cnt_d  = cnt_q - cnt_t'(1);
    end
    if (ctrl.end_reduce) begin
      sq_d = r_next;
    end
    if (ctrl.end_acc) begin
      acc_d = r_next;
    end
    if (ctrl.end_sq) begin
      sq_d  = r_next;
      exp_d = exp_q >> 1;
    end
    if (ctrl.start_acc) begin
      r_d    = '0;
      mplr_d = acc_q;
      cnt_d  = cnt_t'(WIDTH - 1);
    end
    if (ctrl.start_sq) begin
      r_d    = '0;
      // squaring right after an accumulate takes the current square
      mplr_d = sq_q;
      cnt_d  = cnt_t'(WIDTH - 1);
    end
    if (ctrl.accept) begin
      mod_d  = mod_in;
      exp_d  = WIDTH'(in_i.exponent);
      acc_d  = word_t'(1);
      r_d    = '0;
      mplr_d = WIDTH'(in_i.base_value);
      cnt_d  = cnt_t'(WIDTH - 1);
      err_d  = (mod_in == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    mod_q  <= mod_d;
    exp_q  <= exp_d;
    sq_q   <= sq_d;
    acc_q  <= acc_d;
    r_q    <= r_d;
    mplr_q <= mplr_d;
    cnt_q  <= cnt_d;
    err_q  <= err_d;
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    res_err_d   = res_err_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (ctrl.out_load) begin
      out_valid_d = 1'b1;
      res_d       = err_q ? '0 : DataW'(acc_q);
      res_err_d   = err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q     <= res_d;
    res_err_q <= res_err_d;
  end

  assign in_i.ready          = ctrl.in_ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.power_result  = res_q;
  assign out_o.modulus_error = res_err_q;

`ifndef SYNTHESIS
  // zero modulus on an accepted transaction raises the error flag
  a_err_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (mod_in == '0)) |=> err_q)
    else $error("zero modulus did not set the error flag");

  // partial remainder stays reduced while the step unit runs
  a_rem_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.mul_step |-> (r_q < mod_q))
    else $error("partial remainder not below modulus");

  // square is reduced once the base reduction has finished
  a_sq_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.mul_step && !ctrl.sel_reduce) |-> (sq_q < mod_q))
    else $error("square not below modulus");

  // no new result is loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |-> !(out_valid_q && !out_o.ready))
    else $error("result register overwritten");
`endif

endmodule

// ----- hw/rtl/mm_step_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_step_unit
// One shift-add reduction step: r_o = (2*r_i + addend_i) mod mod_i, for
// r_i, addend_i below mod_i (or addend of one).
// ----------------------------------------------------------------------------
module mm_step_unit (
  input  mm_pkg::word_t r_i,
  input  mm_pkg::word_t addend_i,
  input  mm_pkg::word_t mod_i,
  output mm_pkg::word_t r_o
);
  import mm_pkg::*;

  localparam int unsigned SumW = WIDTH + 2;

  logic [SumW-1:0] sum;
  logic [SumW-1:0] mod1;
  logic [SumW-1:0] mod2;
  logic [SumW-1:0] diff1;
  logic [SumW-1:0] diff2;

  // doubled remainder plus addend stays below three times the modulus
  assign sum   = {1'b0, r_i, 1'b0} + {2'b00, addend_i};
  assign mod1  = {2'b00, mod_i};
  assign mod2  = {1'b0, mod_i, 1'b0};
  assign diff1 = sum - mod1;
  assign diff2 = sum - mod2;

  always_comb begin
    if (sum >= mod2) begin
      r_o = diff2[WIDTH-1:0];
    end else if (sum >= mod1) begin
      r_o = diff1[WIDTH-1:0];
    end else begin
      r_o = sum[WIDTH-1:0];
    end
  end

endmodule

// ----- hw/rtl/mm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_ctrl
// Sequencer: base reduction, then per exponent bit an optional accumulator
// multiply and a squaring, each one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mm_pkg::mm_status_t status_i,
  output mm_pkg::mm_ctrl_t   ctrl_o
);
  import mm_pkg::*;

  mm_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and control outputs
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      StIdle: begin
        ctrl_o.in_ready = 1'b1;
        if (status_i.in_valid) begin
          ctrl_o.accept = 1'b1;
          state_d = status_i.mod_zero ? StFinish : StReduce;
        end
      end
      StReduce: begin
        ctrl_o.mul_step   = 1'b1;
        ctrl_o.sel_reduce = 1'b1;
        if (status_i.cnt_last) begin
          ctrl_o.end_reduce = 1'b1;
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (status_i.exp_zero) begin
          state_d = StFinish;
        end else if (status_i.exp_lsb) begin
          ctrl_o.start_acc = 1'b1;
          state_d = StMulAcc;
        end else begin
          ctrl_o.start_sq = 1'b1;
          state_d = StMulSq;
        end
      end
      StMulAcc: begin
        ctrl_o.mul_step = 1'b1;
        if (status_i.cnt_last) begin
          ctrl_o.end_acc  = 1'b1;
          ctrl_o.start_sq = 1'b1;
          state_d = StMulSq;
        end
      end
      StMulSq: begin
        ctrl_o.mul_step = 1'b1;
        if (status_i.cnt_last) begin
          ctrl_o.end_sq = 1'b1;
          state_d = StCheck;
        end
      end
      StFinish: begin
        if (!status_i.out_busy) begin
          ctrl_o.out_load = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

// ----- bench/tb_modular_exponentiation_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_exponentiation_core
// Self-checking bench for the square-and-multiply modular exponentiation
// core. A directed table covers the zero modulus, zero exponent, unreduced
// base and the extremes of each operand. Random operands with mixed exponent
// lengths and modulus classes follow. Every result transaction is compared
// with a power typed in the table or computed here from double-width
// products; both channels stall at random except in the last random phase.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation_core;
  import mm_pkg::*;

  localparam int unsigned RandPerPhase = 87;
  localparam int unsigned DrainCycles  = 2200;
  localparam field_t      AllOnes      = '1;

  typedef logic [2*WIDTH-1:0] wide_t;

  // expected result of one transaction
  typedef struct packed {
    field_t power;
    logic   err;
  } power_res_t;

  // one row of the directed table; typed rows carry their own answer
  typedef struct {
    field_t base;
    field_t expo;
    field_t modv;
    bit     typed;
    field_t power;
    bit     err;
  } stim_row_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   sender_idle_pct;
  int   recv_idle_pct;

  power_res_t power_expect_q[$];

  mm_in_if  in_ch ();
  mm_out_if out_ch ();

  modular_exponentiation_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // 12 ns clock
  always #6 clk = ~clk;

  // base^expo mod modv, right-to-left, exact double-width products
  function automatic power_res_t predict_power(field_t base, field_t expo, field_t modv);
    word_t      sq;
    word_t      e;
    word_t      m;
    word_t      acc;
    power_res_t res;
    sq  = word_t'(base);
    e   = word_t'(expo);
    m   = word_t'(modv);
    acc = word_t'(1);
    if (m == '0) begin
      res.power = '0;
      res.err   = 1'b1;
    end else begin
      for (int i = 0; i < WIDTH && e != '0; i++) begin
        if (e[0]) begin
          acc = word_t'((wide_t'(acc) * wide_t'(sq)) % wide_t'(m));
        end
        sq = word_t'((wide_t'(sq) * wide_t'(sq)) % wide_t'(m));
        e  = e >> 1;
      end
      res.power = field_t'(acc);
      res.err   = 1'b0;
    end
    return res;
  endfunction

  // drive one operand transaction; valid is left high after the handshake
  task automatic send_operands(field_t base, field_t expo, field_t modv, power_res_t res);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.base_value <= base;
    in_ch.exponent   <= expo;
    in_ch.modulus    <= modv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    power_expect_q.push_back(res);
  endtask

  // receiver: random back-pressure and result checking
  always @(posedge clk) begin
    power_res_t exp_res;
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (power_expect_q.size() == 0) begin
        $error("result transaction with none expected: power_result %h", out_ch.power_result);
        fail_count++;
      end else begin
        exp_res = power_expect_q.pop_front();
        if (out_ch.power_result !== exp_res.power) begin
          $error("power_result: expected %h, actual %h", exp_res.power,
                 out_ch.power_result);
          fail_count++;
        end
        if (out_ch.modulus_error !== exp_res.err) begin
          $error("modulus_error: expected %b, actual %b", exp_res.err,
                 out_ch.modulus_error);
          fail_count++;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    stim_row_t  dir_tab [20];
    power_res_t res;
    field_t     b;
    field_t     e;
    field_t     m;
    wide_t      mask;
    int unsigned len;
    int unsigned kind;

    clk              = 1'b0;
    rst_n            = 1'b0;
    fail_count       = 0;
    in_ch.valid      = 1'b0;
    in_ch.base_value = '0;
    in_ch.exponent   = '0;
    in_ch.modulus    = '0;
    out_ch.ready     = 1'b0;
    sender_idle_pct  = 30;
    recv_idle_pct    = 56;

    dir_tab = '{
      // zero modulus, whatever the exponent
      '{32'd0,        32'd0,        32'd0,        1'b1, 32'd0,  1'b1},
      '{AllOnes,      AllOnes,      32'd0,        1'b1, 32'd0,  1'b1},
      '{32'd3,        32'd2,        32'd0,        1'b1, 32'd0,  1'b1},
      // zero exponent gives 1 unreduced
      '{32'd7,        32'd0,        32'd1,        1'b1, 32'd1,  1'b0},
      '{AllOnes,      32'd0,        32'd5,        1'b1, 32'd1,  1'b0},
      '{32'd0,        32'd0,        AllOnes,      1'b1, 32'd1,  1'b0},
      // extremes
      '{32'd0,        32'd1,        AllOnes,      1'b1, 32'd0,  1'b0},
      '{32'd1,        AllOnes,      AllOnes,      1'b1, 32'd1,  1'b0},
      '{AllOnes,      32'd1,        AllOnes,      1'b1, 32'd0,  1'b0},
      '{AllOnes,      AllOnes,      AllOnes,      1'b1, 32'd0,  1'b0},
      '{32'd7,        32'd1,        32'd1,        1'b1, 32'd0,  1'b0},
      '{AllOnes,      AllOnes,      32'd1,        1'b1, 32'd0,  1'b0},
      '{32'd2,        32'd10,       32'd1000,     1'b1, 32'd24, 1'b0},
      // unreduced base, then rows whose answer is predicted
      '{32'd100,      32'd1,        32'd7,        1'b1, 32'd2,  1'b0},
      '{AllOnes,      32'd2,        32'hFFFFFFFE, 1'b0, 32'd0,  1'b0},
      '{32'hDEADBEEF, AllOnes,      32'hFFFFFFFB, 1'b0, 32'd0,  1'b0},
      '{32'h80000000, 32'h80000000, 32'h80000001, 1'b0, 32'd0,  1'b0},
      '{32'd12345,    32'd65537,    AllOnes,      1'b0, 32'd0,  1'b0},
      '{AllOnes,      32'd3,        32'h7FFFFFFF, 1'b0, 32'd0,  1'b0},
      '{32'h55555555, 32'hAAAAAAAA, 32'd2,        1'b0, 32'd0,  1'b0}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_tab[i]) begin
      if (dir_tab[i].typed) begin
        res.power = dir_tab[i].power;
        res.err   = dir_tab[i].err;
      end else begin
        res = predict_power(dir_tab[i].base, dir_tab[i].expo, dir_tab[i].modv);
      end
      send_operands(dir_tab[i].base, dir_tab[i].expo, dir_tab[i].modv, res);
    end

    // random operands over three stall patterns
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          sender_idle_pct = 30;
          recv_idle_pct   = 56;
        end
        1: begin
          sender_idle_pct = 56;
          recv_idle_pct   = 30;
        end
        default: begin
          sender_idle_pct = 0;
          recv_idle_pct   = 0;
        end
      endcase
      repeat (RandPerPhase) begin
        // modulus class: zero, one, small, near the top, or anything
        kind = $urandom_range(15);
        case (kind)
          0:       m = '0;
          1:       m = 32'd1;
          2, 3:    m = field_t'($urandom_range(255, 2));
          4, 5:    m = AllOnes - field_t'($urandom_range(64, 0));
          default: m = field_t'($urandom);
        endcase
        kind = $urandom_range(7);
        case (kind)
          0:       b = '0;
          1:       b = 32'd1;
          2:       b = AllOnes;
          3:       b = m - 32'd1;
          default: b = field_t'($urandom);
        endcase
        // exponent of random bit length, top bit set so the length is exact
        len = $urandom_range(32, 0);
        if (len == 0) begin
          e = '0;
        end else begin
          mask = (wide_t'(1) << len) - wide_t'(1);
          e    = (field_t'($urandom) & field_t'(mask)) | (field_t'(1) << (len - 1));
        end
        send_operands(b, e, m, predict_power(b, e, m));
      end
    end

    in_ch.valid <= 1'b0;
    while (power_expect_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(40_000_000);
    $display("FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/mm_pkg.sv
hw/rtl/mm_in_if.sv
hw/rtl/mm_out_if.sv
hw/rtl/mm_step_unit.sv
hw/rtl/mm_ctrl.sv
hw/rtl/modular_exponentiation_core.sv
bench/tb_modular_exponentiation_core.sv
